// ===== rtl/core/dspe_pkg.sv =====
// ---------------------------------------------------------------------------
// dspe_pkg
// Shared constants, codes and types of the difference sign pattern encoder.
// ---------------------------------------------------------------------------
package dspe_pkg;

   localparam int MAX_COLUMNS   = 16;
   localparam int FRACTION_BITS = 16;

   localparam int COORD_W     = 32;
   localparam int MAG_W       = COORD_W + 1;
   localparam int TOL_W       = 16;
   localparam int LEN_W       = 5;
   localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
   localparam int STORE_DEPTH = MAX_COLUMNS - 1;
   localparam int SLOT_W      = $clog2(STORE_DEPTH);
   localparam int DIV_SHIFT   = COORD_W - FRACTION_BITS;
   localparam int CNT_W       = $clog2(COORD_W);
   localparam int QUEUE_DEPTH = 2;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_RELATIVE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_MISSING  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_TOL      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH    = 2'd3;

   localparam logic [TOL_W-1:0] ZERO_TOL_RESET   = 16'd1;
   localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 5'd16;

   // symbol codes
   localparam logic [1:0] SYM_MISSING   = 2'd0;
   localparam logic [1:0] SYM_NEGATIVE  = 2'd1;
   localparam logic [1:0] SYM_NEAR_ZERO = 2'd2;
   localparam logic [1:0] SYM_POSITIVE  = 2'd3;

   // job kinds, decided by the front end
   localparam logic [2:0] KIND_MISSING = 3'd0;
   localparam logic [2:0] KIND_ZERO    = 3'd1;
   localparam logic [2:0] KIND_PLAIN   = 3'd2;
   localparam logic [2:0] KIND_DIVZERO = 3'd3;
   localparam logic [2:0] KIND_DIVIDE  = 3'd4;

   typedef struct packed {
      logic             relative_mode;
      logic             drop_rows_with_missing;
      logic [TOL_W-1:0] zero_tolerance;
      logic [LEN_W-1:0] row_length;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               neg;
      logic [MAG_W-1:0]   diff_mag;
      logic [COORD_W-1:0] prev_mag;
      logic [SLOT_W-1:0]  slot;
      logic               row_end;
      logic               dropped;
   } job_type;

   typedef struct packed {
      logic [COORD_W-1:0] value;
      logic               missing;
      logic               sat;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [COORD_W-1:0] signature;
      logic               signature_missing;
      logic [1:0]         symbol;
      logic               saturated;
      logic               row_dropped;
      logic               last_in_row;
   } rsp_type;

endpackage

// ===== rtl/core/dspe_if.sv =====
// ---------------------------------------------------------------------------
// dspe_req_if / dspe_rsp_if
// Valid/ready channels for coordinates in and signatures out.
// ---------------------------------------------------------------------------
interface dspe_req_if import dspe_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] coordinate;
   logic                      coordinate_missing;

   modport source (output valid, output coordinate, output coordinate_missing, input ready);
   modport sink (input valid, input coordinate, input coordinate_missing, output ready);
endinterface

interface dspe_rsp_if import dspe_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] signature;
   logic                      signature_missing;
   logic [1:0]                symbol;
   logic                      saturated;
   logic                      row_dropped;
   logic                      last_in_row;

   modport source (output valid, output signature, output signature_missing, output symbol,
                   output saturated, output row_dropped, output last_in_row, input ready);
   modport sink (input valid, input signature, input signature_missing, input symbol,
                 input saturated, input row_dropped, input last_in_row, output ready);
endinterface

// ===== rtl/core/dspe_ram.sv =====
// ---------------------------------------------------------------------------
// dspe_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module dspe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dspe_queue.sv =====
// ---------------------------------------------------------------------------
// dspe_queue
// Short job queue between the classifying front end and the back end.
// ---------------------------------------------------------------------------
module dspe_queue import dspe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   assign full    = (count_ff == CNT_QW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_QW'(push) - CNT_QW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");

endmodule

// ===== rtl/core/dspe_front.sv =====
// ---------------------------------------------------------------------------
// dspe_front
// Takes coordinates, forms the difference of each pair and classifies it.
// ---------------------------------------------------------------------------
module dspe_front import dspe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   dspe_req_if.sink       req,
   input  logic           queue_full,
   output logic           push,
   output job_type        push_job
);

   logic [COL_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0] prev_ff, prev_in;
   logic               prev_miss_ff, prev_miss_in;
   logic               row_miss_ff, row_miss_in;

   logic [COL_W-1:0]   eff_len;
   logic [COL_W-1:0]   col_next;
   logic [MAG_W-1:0]   diff;
   logic               diff_neg;
   logic [MAG_W-1:0]   diff_mag;
   logic [COORD_W-1:0] prev_mag;
   logic               pair_missing;
   logic               near_zero;
   logic               accept;
   logic               row_end;

   // row length clamped into the supported range
   always_comb begin
      priority if (int'(cfg.row_length) < 2) begin
         eff_len = COL_W'(2);
      end else if (int'(cfg.row_length) > MAX_COLUMNS) begin
         eff_len = COL_W'(MAX_COLUMNS);
      end else begin
         eff_len = COL_W'(cfg.row_length);
      end
   end

   assign req.ready = (col_ff == '0) || !queue_full;
   assign accept    = req.valid && req.ready;
   assign push      = accept && (col_ff != '0);

   assign col_next     = col_ff + 1'b1;
   assign row_end      = (col_next >= eff_len);
   assign diff         = {req.coordinate[COORD_W-1], req.coordinate} - {prev_ff[COORD_W-1], prev_ff};
   assign diff_neg     = diff[MAG_W-1];
   assign diff_mag     = diff_neg ? (MAG_W'(0) - diff) : diff;
   assign prev_mag     = prev_ff[COORD_W-1] ? (COORD_W'(0) - prev_ff) : prev_ff;
   assign pair_missing = prev_miss_ff || req.coordinate_missing;
   assign near_zero    = (diff_mag <= MAG_W'(cfg.zero_tolerance));

   always_comb begin
      push_job.diff_mag = diff_mag;
      push_job.prev_mag = prev_mag;
      push_job.slot     = SLOT_W'(col_ff - 1'b1);
      push_job.row_end  = row_end;
      push_job.dropped  = cfg.drop_rows_with_missing && (row_miss_ff || pair_missing);
      push_job.neg      = diff_neg;
      priority if (pair_missing) begin
         push_job.kind = KIND_MISSING;
      end else if (near_zero) begin
         push_job.kind = KIND_ZERO;
      end else if (!cfg.relative_mode) begin
         push_job.kind = KIND_PLAIN;
      end else if (prev_ff == '0) begin
         push_job.kind = KIND_DIVZERO;
      end else begin
         push_job.kind = KIND_DIVIDE;
         // quotient sign follows both operands
         push_job.neg  = diff_neg ^ prev_ff[COORD_W-1];
      end
   end

   always_comb begin
      col_in       = col_ff;
      prev_in      = prev_ff;
      prev_miss_in = prev_miss_ff;
      row_miss_in  = row_miss_ff;
      if (accept) begin
         prev_in      = req.coordinate;
         prev_miss_in = req.coordinate_missing;
         if (col_ff == '0) begin
            col_in = COL_W'(1);
         end else if (row_end) begin
            col_in      = '0;
            row_miss_in = 1'b0;
         end else begin
            col_in      = col_next;
            row_miss_in = row_miss_ff || pair_missing;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         prev_ff      <= '0;
         prev_miss_ff <= 1'b0;
         row_miss_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         prev_ff      <= prev_in;
         prev_miss_ff <= prev_miss_in;
         row_miss_ff  <= row_miss_in;
      end
   end

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      (push && push_job.row_end) |=> (col_ff == '0 && !row_miss_ff))
      else $error("row state not cleared after the last coordinate");

endmodule

// ===== rtl/core/dspe_back.sv =====
// ---------------------------------------------------------------------------
// dspe_back
// Finishes each job (saturation, bit-serial divide), keeps the row's
// signatures and plays the run out at row end.
// ---------------------------------------------------------------------------
module dspe_back import dspe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       queue_empty,
   output logic       pop,
   input  job_type    pop_job,
   dspe_rsp_if.source rsp
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_RD   = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(1) << (COORD_W - 1);

   logic [2:0]         state_ff, state_in;
   job_type            job_ff, job_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  k_ff, k_in;
   rsp_type            out_ff, out_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               wr_en;
   entry_type          wr_data;
   entry_type          direct;
   entry_type          rd_entry;
   logic [ENTRY_W-1:0] rd_data;
   logic               div_ovf;
   logic [MAG_W-1:0]   trial;
   logic [MAG_W-1:0]   trial_sub;
   logic               trial_ge;
   logic               load;
   logic               last;

   function automatic entry_type clip(input logic [MAG_W-1:0] mag, input logic neg);
      entry_type          e;
      logic [COORD_W-1:0] m;
      e.missing = 1'b0;
      if (neg) begin
         e.sat = (mag > NEG_LIMIT);
         m     = e.sat ? NEG_LIMIT[COORD_W-1:0] : mag[COORD_W-1:0];
         e.value = COORD_W'(0) - m;
      end else begin
         e.sat = (mag > POS_LIMIT);
         m     = e.sat ? POS_LIMIT[COORD_W-1:0] : mag[COORD_W-1:0];
         e.value = m;
      end
      return e;
   endfunction

   function automatic logic [1:0] symbol_of(input entry_type e, input logic [TOL_W-1:0] tol);
      logic [COORD_W-1:0] mag;
      logic [1:0]         sym;
      mag = e.value[COORD_W-1] ? (COORD_W'(0) - e.value) : e.value;
      priority if (e.missing) begin
         sym = SYM_MISSING;
      end else if (mag <= COORD_W'(tol)) begin
         sym = SYM_NEAR_ZERO;
      end else if (e.value[COORD_W-1]) begin
         sym = SYM_NEGATIVE;
      end else begin
         sym = SYM_POSITIVE;
      end
      return sym;
   endfunction

   // quotient would need more than the word: saturate without dividing
   assign div_ovf = ({{DIV_SHIFT{1'b0}}, job_ff.diff_mag}
                     >= {1'b0, job_ff.prev_mag, {DIV_SHIFT{1'b0}}});

   // one restoring step per cycle
   assign trial     = {rem_ff, quo_ff[COORD_W-1]};
   assign trial_sub = trial - {1'b0, job_ff.prev_mag};
   assign trial_ge  = (trial >= {1'b0, job_ff.prev_mag});

   assign rd_entry = entry_type'(rd_data);
   assign last     = (k_ff == job_ff.slot);

   always_comb begin
      direct = '0;
      unique case (job_ff.kind)
         KIND_MISSING: direct.missing = 1'b1;
         KIND_ZERO:    direct = '0;
         KIND_PLAIN:   direct = clip(job_ff.diff_mag, job_ff.neg);
         KIND_DIVZERO, KIND_DIVIDE: begin
            direct.sat   = 1'b1;
            direct.value = job_ff.neg ? NEG_LIMIT[COORD_W-1:0] : POS_LIMIT[COORD_W-1:0];
         end
         default:      direct = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_data      = direct;
      load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               job_in   = pop_job;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (job_ff.kind == KIND_DIVIDE && !div_ovf) begin
               rem_in   = COORD_W'(job_ff.diff_mag[MAG_W-1:DIV_SHIFT]);
               quo_in   = {job_ff.diff_mag[DIV_SHIFT-1:0], {FRACTION_BITS{1'b0}}};
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               wr_en    = 1'b1;
               k_in     = '0;
               state_in = job_ff.row_end ? ST_RD : ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[COORD_W-1:0] : trial[COORD_W-1:0];
            quo_in = {quo_ff[COORD_W-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            wr_en    = 1'b1;
            wr_data  = clip(MAG_W'(quo_ff), job_ff.neg);
            k_in     = '0;
            state_in = job_ff.row_end ? ST_RD : ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load                     = 1'b1;
               out_in.signature         = rd_entry.value;
               out_in.signature_missing = rd_entry.missing;
               out_in.symbol            = symbol_of(rd_entry, cfg.zero_tolerance);
               out_in.saturated         = rd_entry.sat;
               out_in.row_dropped       = job_ff.dropped;
               out_in.last_in_row       = last;
               rsp_valid_in             = 1'b1;
               k_in                     = k_ff + 1'b1;
               state_in                 = last ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dspe_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (job_ff.slot),
      .wr_data (wr_data),
      .rd_addr (k_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      out_ff <= out_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.signature         = out_ff.signature;
   assign rsp.signature_missing = out_ff.signature_missing;
   assign rsp.symbol            = out_ff.symbol;
   assign rsp.saturated         = out_ff.saturated;
   assign rsp.row_dropped       = out_ff.row_dropped;
   assign rsp.last_in_row       = out_ff.last_in_row;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < job_ff.prev_mag))
      else $error("partial remainder not below divisor");

   a_run_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (load && last) |=> (state_ff == ST_IDLE && rsp.last_in_row && rsp.valid))
      else $error("run did not end after its last item");

endmodule

// ===== rtl/core/difference_sign_pattern_encoder_unit.sv =====
// ---------------------------------------------------------------------------
// difference_sign_pattern_encoder_unit
// Sign-of-difference symbolisation of state rows, one coordinate per item.
// ---------------------------------------------------------------------------
// Coordinates of a row arrive one per item (signed Q16.16 with a missing
// flag). The first coordinate of a row is taken and gives nothing. Every
// later coordinate gives a signature: plain difference, or relative change
// in relative mode, kept in a small store; after the row's last coordinate
// the whole run comes out in column order. A plain, missing, near-zero,
// divide-by-zero or overflowing signature is stored straight from the back
// end's execute state; any other relative change goes through the
// bit-serial divider that produces one quotient bit a cycle. Each item of
// the run at row end waits for the registered read of the signature store.
// A two-entry job queue sits between the classifying front end and the back
// end, so coordinates keep being taken while the queue has room during a
// division or a run, and an output register lets the back end go on while
// a result waits to be taken. Configuration is four registers: relative
// mode, drop mode, zero tolerance and row length (clamped to 2..16).
// ---------------------------------------------------------------------------
module difference_sign_pattern_encoder_unit import dspe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dspe_req_if.sink              req_chan,
   dspe_rsp_if.source            rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type cfg_ff, cfg_in;
   logic    queue_full;
   logic    queue_empty;
   logic    push;
   logic    pop;
   job_type push_job;
   job_type pop_job;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RELATIVE_MODE: cfg_in.relative_mode          = csr_write_data[0];
            CSR_DROP_MISSING:  cfg_in.drop_rows_with_missing = csr_write_data[0];
            CSR_ZERO_TOL:      cfg_in.zero_tolerance         = csr_write_data[TOL_W-1:0];
            CSR_ROW_LENGTH:    cfg_in.row_length             = csr_write_data[LEN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.relative_mode          <= 1'b1;
         cfg_ff.drop_rows_with_missing <= 1'b1;
         cfg_ff.zero_tolerance         <= ZERO_TOL_RESET;
         cfg_ff.row_length             <= ROW_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dspe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   dspe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   dspe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .pop         (pop),
      .pop_job     (pop_job),
      .rsp         (rsp_chan)
   );

endmodule

// ===== tb/difference_sign_pattern_encoder_unit_tb.sv =====
// ---------------------------------------------------------------------------
// difference_sign_pattern_encoder_unit_tb
// Self-checking bench for the difference sign pattern encoder.
// ---------------------------------------------------------------------------
// Rows of coordinates go in over the request channel in bursts. Runs of
// signatures come back over the response channel, which stalls on patterns
// of its own. A predictor inside the bench keeps its own row state and
// register copy, and it queues the signatures that each accepted coordinate
// should cause. Every result is compared with the oldest queued signature.
// A short directed set of two-coordinate rows covers division by zero,
// overflow, missing pairs and near-zero changes. Random phases follow, and
// each one writes all four registers, including clamped row lengths and the
// extremes of the tolerance. A phase often ends part way through a row.
// ---------------------------------------------------------------------------
module difference_sign_pattern_encoder_unit_tb;
   import dspe_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   // up to three divisions can still be in flight after the last result
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 320;

   typedef struct {
      logic               relative;
      logic signed [31:0] first;
      logic               first_missing;
      logic signed [31:0] second;
      logic               second_missing;
      logic               typed;
      rsp_type            want;
   } pair_case_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   dspe_req_if req_chan ();
   dspe_rsp_if rsp_chan ();

   difference_sign_pattern_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   cfg_type            shadow_cfg;
   logic signed [31:0] held_coordinate;
   logic               held_missing;
   int                 column_position;
   logic               row_has_missing;
   entry_type          signature_store [STORE_DEPTH];
   rsp_type            pending_signatures [$];

   int failures;
   int cycle_count;
   int items_sent;
   int settings_used;
   int signatures_checked;
   int saturated_seen;
   int missing_seen;
   int dropped_seen;
   int burst_left;
   int rx_mode;
   int rx_phase;
   logic signed [31:0] last_sent;

   // two-coordinate rows, run with drop mode on and a tolerance of one
   pair_case_type directed_pairs [13] = '{
      '{1'b1, 32'sh0000_0000, 1'b0, 32'sh0001_0000, 1'b0, 1'b1,
        '{32'h7FFF_FFFF, 1'b0, SYM_POSITIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b1, 32'sh0000_0000, 1'b0, 32'shFFFF_0000, 1'b0, 1'b1,
        '{32'h8000_0000, 1'b0, SYM_NEGATIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b1, 32'sh0001_0000, 1'b0, 32'sh0002_0000, 1'b0, 1'b1,
        '{32'h0001_0000, 1'b0, SYM_POSITIVE, 1'b0, 1'b0, 1'b1}},
      '{1'b1, 32'sh0000_0005, 1'b1, 32'sh0000_0007, 1'b0, 1'b1,
        '{32'h0000_0000, 1'b1, SYM_MISSING, 1'b0, 1'b1, 1'b1}},
      '{1'b1, 32'sh0000_0007, 1'b0, 32'sh0000_0009, 1'b1, 1'b1,
        '{32'h0000_0000, 1'b1, SYM_MISSING, 1'b0, 1'b1, 1'b1}},
      '{1'b1, 32'sh0000_0064, 1'b0, 32'sh0000_0065, 1'b0, 1'b1,
        '{32'h0000_0000, 1'b0, SYM_NEAR_ZERO, 1'b0, 1'b0, 1'b1}},
      '{1'b1, 32'sh0000_0064, 1'b0, 32'sh0000_0066, 1'b0, 1'b0, '0},
      '{1'b1, 32'sh0000_0001, 1'b0, 32'sh7FFF_FFFF, 1'b0, 1'b1,
        '{32'h7FFF_FFFF, 1'b0, SYM_POSITIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b1, 32'sh0000_0001, 1'b0, 32'sh8000_0000, 1'b0, 1'b1,
        '{32'h8000_0000, 1'b0, SYM_NEGATIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b1, 32'sh8000_0000, 1'b0, 32'sh7FFF_FFFF, 1'b0, 1'b0, '0},
      '{1'b0, 32'sh8000_0000, 1'b0, 32'sh7FFF_FFFF, 1'b0, 1'b1,
        '{32'h7FFF_FFFF, 1'b0, SYM_POSITIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 32'sh7FFF_FFFF, 1'b0, 32'sh8000_0000, 1'b0, 1'b1,
        '{32'h8000_0000, 1'b0, SYM_NEGATIVE, 1'b1, 1'b0, 1'b1}},
      '{1'b0, 32'sh0000_000A, 1'b0, 32'sh0000_0003, 1'b0, 1'b1,
        '{32'hFFFF_FFF9, 1'b0, SYM_NEGATIVE, 1'b0, 1'b0, 1'b1}}
   };

   always #5 clock = ~clock;

   function automatic entry_type form_signature(input logic signed [31:0] earlier,
                                                input logic earlier_missing,
                                                input logic signed [31:0] later,
                                                input logic later_missing);
      entry_type  e;
      longint     diff;
      bit [63:0]  diff_mag;
      bit [63:0]  earlier_mag;
      bit [63:0]  quotient;
      bit [63:0]  negated;
      bit         neg;
      e = '0;
      if (earlier_missing || later_missing) begin
         e.missing = 1'b1;
         return e;
      end
      diff = longint'(later) - longint'(earlier);
      diff_mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (diff_mag <= shadow_cfg.zero_tolerance) begin
         return e;
      end
      neg = diff < 0;
      if (shadow_cfg.relative_mode) begin
         if (earlier == 0) begin
            e.sat = 1'b1;
            e.value = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            return e;
         end
         earlier_mag = (earlier < 0) ? 64'(-longint'(earlier)) : 64'(longint'(earlier));
         quotient = (diff_mag << FRACTION_BITS) / earlier_mag;
         neg = (diff < 0) != (earlier < 0);
      end else begin
         quotient = diff_mag;
      end
      if (neg) begin
         if (quotient > 64'h8000_0000) begin
            e.sat = 1'b1;
            quotient = 64'h8000_0000;
         end
         negated = 64'd0 - quotient;
         e.value = negated[31:0];
      end else begin
         if (quotient > 64'h7FFF_FFFF) begin
            e.sat = 1'b1;
            quotient = 64'h7FFF_FFFF;
         end
         e.value = quotient[31:0];
      end
      return e;
   endfunction

   // the symbol uses the tolerance in force when the run goes out
   function automatic logic [1:0] symbol_for(input entry_type e);
      longint    v;
      bit [63:0] mag;
      v = longint'($signed(e.value));
      mag = (v < 0) ? 64'(-v) : 64'(v);
      if (e.missing) begin
         return SYM_MISSING;
      end
      if (mag <= shadow_cfg.zero_tolerance) begin
         return SYM_NEAR_ZERO;
      end
      return (v > 0) ? SYM_POSITIVE : SYM_NEGATIVE;
   endfunction

   function automatic void encode_coordinate(input logic signed [31:0] c, input logic m);
      int        row_len;
      int        n;
      entry_type e;
      logic      dropped;
      rsp_type   r;
      if (shadow_cfg.row_length < 2) begin
         row_len = 2;
      end else if (shadow_cfg.row_length > MAX_COLUMNS) begin
         row_len = MAX_COLUMNS;
      end else begin
         row_len = int'(shadow_cfg.row_length);
      end
      if (column_position == 0) begin
         held_coordinate = c;
         held_missing = m;
         column_position = 1;
         return;
      end
      e = form_signature(held_coordinate, held_missing, c, m);
      if (column_position - 1 < STORE_DEPTH) begin
         signature_store[column_position-1] = e;
      end
      if (e.missing) begin
         row_has_missing = 1'b1;
      end
      held_coordinate = c;
      held_missing = m;
      column_position++;
      if (column_position < row_len) begin
         return;
      end
      // a row length lowered mid-row ends it here with everything stored so far
      n = (column_position - 1 > STORE_DEPTH) ? STORE_DEPTH : column_position - 1;
      dropped = shadow_cfg.drop_rows_with_missing && row_has_missing;
      for (int k = 0; k < n; k++) begin
         r.signature = signature_store[k].value;
         r.signature_missing = signature_store[k].missing;
         r.symbol = symbol_for(signature_store[k]);
         r.saturated = signature_store[k].sat;
         r.row_dropped = dropped;
         r.last_in_row = (k == n - 1);
         pending_signatures = {pending_signatures, r};
      end
      column_position = 0;
      row_has_missing = 1'b0;
   endfunction

   function automatic void pick_coordinate(output logic signed [31:0] c, output logic m);
      int     choice;
      int     span;
      longint delta;
      choice = $urandom_range(0, 99);
      m = 1'b0;
      if (choice < 8) begin
         m = 1'b1;
         c = $urandom;
      end else if (choice < 42) begin
         // close to the previous coordinate, around the tolerance
         span = int'(shadow_cfg.zero_tolerance) + 8;
         delta = longint'($urandom_range(0, 2 * span)) - span;
         c = 32'(longint'(last_sent) + delta);
      end else if (choice < 57) begin
         c = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      end else if (choice < 65) begin
         case ($urandom_range(0, 4))
            0: c = 32'sh0000_0000;
            1: c = 32'sh7FFF_FFFF;
            2: c = 32'sh8000_0000;
            3: c = 32'sh0000_0001;
            default: c = 32'shFFFF_FFFF;
         endcase
      end else begin
         c = $urandom;
      end
      last_sent = c;
   endfunction

   task automatic send_coordinate(input logic signed [31:0] c, input logic m,
                                  input logic typed, input rsp_type want);
      int gap;
      int queued;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         gap = $urandom_range(1, 5);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_chan.valid <= 1'b1;
      req_chan.coordinate <= c;
      req_chan.coordinate_missing <= m;
      do @(posedge clock); while (!req_chan.ready);
      queued = pending_signatures.size();
      encode_coordinate(c, m);
      if (typed && pending_signatures.size() > queued) begin
         pending_signatures[$] = want;
      end
      items_sent++;
   endtask

   task automatic stop_sending;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_RELATIVE_MODE: shadow_cfg.relative_mode = data[0];
         CSR_DROP_MISSING:  shadow_cfg.drop_rows_with_missing = data[0];
         CSR_ZERO_TOL:      shadow_cfg.zero_tolerance = data[TOL_W-1:0];
         CSR_ROW_LENGTH:    shadow_cfg.row_length = data[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input cfg_type c);
      write_register(CSR_RELATIVE_MODE, CSR_DATA_W'(c.relative_mode));
      write_register(CSR_DROP_MISSING, CSR_DATA_W'(c.drop_rows_with_missing));
      write_register(CSR_ZERO_TOL, CSR_DATA_W'(c.zero_tolerance));
      write_register(CSR_ROW_LENGTH, CSR_DATA_W'(c.row_length));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // all runs out, then time for coordinates that give nothing to settle
   task automatic wait_idle;
      while (pending_signatures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // receiver stalls, switching pattern now and then
   always @(negedge clock) begin
      rx_phase <= rx_phase + 1;
      if (rx_phase % 97 == 96) begin
         rx_mode <= $urandom_range(0, 3);
      end
      case (rx_mode)
         0: rsp_chan.ready <= 1'b1;
         1: rsp_chan.ready <= 1'($urandom_range(0, 1));
         2: rsp_chan.ready <= (rx_phase % 5) >= 2;
         default: rsp_chan.ready <= (rx_phase % 16) >= 12;
      endcase
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_signatures.size() == 0) begin
            $error("signature %h arrived with nothing expected", rsp_chan.signature);
            failures++;
         end else begin
            want = pending_signatures.pop_front();
            signatures_checked++;
            saturated_seen += want.saturated;
            missing_seen += want.signature_missing;
            dropped_seen += want.row_dropped;
            if (rsp_chan.signature !== want.signature) begin
               $error("signature: expected %h, got %h", want.signature, rsp_chan.signature);
               failures++;
            end
            if (rsp_chan.signature_missing !== want.signature_missing) begin
               $error("signature_missing: expected %0d, got %0d",
                      want.signature_missing, rsp_chan.signature_missing);
               failures++;
            end
            if (rsp_chan.symbol !== want.symbol) begin
               $error("symbol: expected %0d, got %0d", want.symbol, rsp_chan.symbol);
               failures++;
            end
            if (rsp_chan.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated, rsp_chan.saturated);
               failures++;
            end
            if (rsp_chan.row_dropped !== want.row_dropped) begin
               $error("row_dropped: expected %0d, got %0d",
                      want.row_dropped, rsp_chan.row_dropped);
               failures++;
            end
            if (rsp_chan.last_in_row !== want.last_in_row) begin
               $error("last_in_row: expected %0d, got %0d",
                      want.last_in_row, rsp_chan.last_in_row);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d signatures outstanding",
                  cycle_count, pending_signatures.size());
         $display("FAIL difference_sign_pattern_encoder_unit");
         $finish;
      end
   end

   initial begin : stimulus
      cfg_type            cfg;
      logic signed [31:0] c;
      logic               m;
      int                 phase;
      int                 phase_items;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_RELATIVE_MODE;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.coordinate = '0;
      req_chan.coordinate_missing = 1'b0;
      rsp_chan.ready = 1'b0;
      rx_mode = 0;
      rx_phase = 0;
      burst_left = 0;
      last_sent = '0;
      failures = 0;
      cycle_count = 0;
      items_sent = 0;
      settings_used = 0;
      signatures_checked = 0;
      saturated_seen = 0;
      missing_seen = 0;
      dropped_seen = 0;
      shadow_cfg = '{1'b1, 1'b1, ZERO_TOL_RESET, ROW_LENGTH_RESET};
      held_coordinate = '0;
      held_missing = 1'b0;
      column_position = 0;
      row_has_missing = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows of two coordinates, reset settings apart from the length
      load_config('{1'b1, 1'b1, 16'd1, 5'd2});
      foreach (directed_pairs[i]) begin
         if (directed_pairs[i].relative != shadow_cfg.relative_mode) begin
            stop_sending();
            wait_idle();
            load_config('{directed_pairs[i].relative, 1'b1, 16'd1, 5'd2});
         end
         send_coordinate(directed_pairs[i].first, directed_pairs[i].first_missing,
                         1'b0, '0);
         send_coordinate(directed_pairs[i].second, directed_pairs[i].second_missing,
                         directed_pairs[i].typed, directed_pairs[i].want);
      end

      // random phases; a phase may stop mid-row so the next settings apply to it
      phase = 0;
      while (items_sent < RANDOM_ITEMS + 26) begin
         stop_sending();
         wait_idle();
         cfg.relative_mode = (phase < 6) ? phase[0] : 1'($urandom_range(0, 1));
         cfg.drop_rows_with_missing = (phase < 6) ? phase[1] : 1'($urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0: cfg.zero_tolerance = 16'($urandom_range(0, 8));
            1: cfg.zero_tolerance = 16'($urandom_range(0, 300));
            2: cfg.zero_tolerance = 16'($urandom_range(0, 65535));
            default: cfg.zero_tolerance = 16'hFFFF;
         endcase
         cfg.row_length = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(2, 16));
         case (phase)
            0: begin cfg.zero_tolerance = 16'd0; cfg.row_length = 5'd16; end
            1: begin cfg.zero_tolerance = 16'hFFFF; cfg.row_length = 5'd2; end
            2: cfg.row_length = 5'd0;
            3: cfg.row_length = 5'd31;
            4: cfg.row_length = 5'd1;
            5: cfg.row_length = 5'd17;
            default: ;
         endcase
         load_config(cfg);
         phase_items = $urandom_range(16, 48);
         repeat (phase_items) begin
            pick_coordinate(c, m);
            send_coordinate(c, m, 1'b0, '0);
         end
         phase++;
      end
      stop_sending();

      while (pending_signatures.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d coordinate items under %0d register settings, checked %0d signatures",
               items_sent, settings_used, signatures_checked);
      $display("of those %0d saturated, %0d missing, %0d in dropped rows",
               saturated_seen, missing_seen, dropped_seen);
      if (failures == 0) begin
         $display("PASS difference_sign_pattern_encoder_unit");
      end else begin
         $display("FAIL difference_sign_pattern_encoder_unit");
      end
      $finish;
   end

endmodule

// ===== difference_sign_pattern_encoder_unit.f =====
rtl/core/dspe_pkg.sv
rtl/core/dspe_if.sv
rtl/core/dspe_ram.sv
rtl/core/dspe_queue.sv
rtl/core/dspe_front.sv
rtl/core/dspe_back.sv
rtl/core/difference_sign_pattern_encoder_unit.sv
tb/difference_sign_pattern_encoder_unit_tb.sv
